FILE: hw/rtl/sgrv_pkg.sv
// Package for the SGR color code validator: verdict and phase codes,
// the number-check result type and the supported-code table.
// No dependencies.
package sgrv_pkg;

  localparam int CHAR_W    = 16;
  localparam int VERDICT_W = 2;
  localparam int PHASE_W   = 3;
  localparam int ACC_W     = 9;
  localparam int SEEN_W    = 2;
  // accumulator times ten plus a digit: up to 5119
  localparam int PROD_W    = ACC_W + 4;

  localparam logic [ACC_W-1:0]  ACC_MAX  = 9'd511;
  localparam logic [ACC_W-1:0]  BYTE_MAX = 9'd255;
  localparam logic [ACC_W-1:0]  CODE_FG_EXT = 9'd38;
  localparam logic [ACC_W-1:0]  CODE_BG_EXT = 9'd48;
  localparam logic [ACC_W-1:0]  MODE_RGB     = 9'd2;
  localparam logic [ACC_W-1:0]  MODE_INDEXED = 9'd5;
  localparam logic [SEEN_W-1:0] SEEN_MAX = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_SEMI  = 16'h003B;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 16'h0030;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 16'h0039;

  // verdict codes
  localparam logic [VERDICT_W-1:0] VERDICT_DEFAULT = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_VALID   = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_INVALID = 2'd2;

  // parse phases; BYTES1..BYTES3 count extended-color bytes still expected
  localparam logic [PHASE_W-1:0] PH_NORMAL = 3'd0;
  localparam logic [PHASE_W-1:0] PH_BYTES1 = 3'd1;
  localparam logic [PHASE_W-1:0] PH_BYTES2 = 3'd2;
  localparam logic [PHASE_W-1:0] PH_BYTES3 = 3'd3;
  localparam logic [PHASE_W-1:0] PH_XMODE  = 3'd4;

  typedef struct packed {
    logic               fail;
    logic [PHASE_W-1:0] phase;
  } num_check_t;

  // Supported SGR codes outside the extended-color introducers
  function automatic logic code_supported(input logic [ACC_W-1:0] n);
    logic ok;
    ok = 1'b0;
    if (n <= 9'd4 || n == 9'd7 || n == 9'd9) ok = 1'b1;
    if (n >= 9'd21 && n <= 9'd25) ok = 1'b1;
    if (n == 9'd27 || n == 9'd29) ok = 1'b1;
    if (n >= 9'd30 && n <= 9'd37) ok = 1'b1;
    if (n == 9'd39 || n == 9'd49) ok = 1'b1;
    if (n >= 9'd40 && n <= 9'd47) ok = 1'b1;
    if (n == 9'd53 || n == 9'd55 || n == 9'd59) ok = 1'b1;
    if (n >= 9'd90 && n <= 9'd97) ok = 1'b1;
    if (n >= 9'd100 && n <= 9'd107) ok = 1'b1;
    return ok;
  endfunction

endpackage

FILE: hw/rtl/sgrv_if.sv
// Stream interfaces for the SGR color code validator: character input
// and verdict output, valid/ready handshake. Depends on sgrv_pkg.
interface sgrv_char_if
  import sgrv_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ch;
  logic              is_end;

  modport source (output valid, output ch, output is_end, input ready);
  modport sink   (input valid, input ch, input is_end, output ready);
endinterface

interface sgrv_verdict_if
  import sgrv_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

FILE: hw/rtl/sgr_color_code_validator_top.sv
// Top level of the SGR color code validator: input register, character
// parser with number check, verdict output register.
// Depends on sgrv_pkg, sgrv_if.sv and sgrv_num_check.
//
//  channel   dir  handshake      payload
//  chars     in   valid/ready    ch[15:0], is_end
//  result    out  valid/ready    verdict[1:0]
//
// One character per cycle sustained while no terminator is held; a verdict is
// presented after its terminator passes the input register and is parsed into
// the result register.
// The parse state update is the single path between the two registers.
// rst (synchronous) empties both registers and returns to the start of a string.
// A held verdict stalls only terminators; other characters flow until a terminator waits.
module sgr_color_code_validator_top
  import sgrv_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  sgrv_char_if.sink      chars,
  sgrv_verdict_if.source result
);

  // input register
  logic              s1_valid;
  logic [CHAR_W-1:0] s1_ch;
  logic              s1_is_end;
  logic              s1_adv;

  // parse state
  logic [PHASE_W-1:0] phase, phase_next;
  logic [ACC_W-1:0]   acc, acc_next;
  logic               failed, failed_next;
  logic [SEEN_W-1:0]  seen, seen_next;
  logic               all_zero, all_zero_next;

  // output register
  logic                 out_valid;
  logic [VERDICT_W-1:0] verdict;
  logic [VERDICT_W-1:0] verdict_next;

  num_check_t        chk;
  logic              is_digit;
  logic [PROD_W-1:0] prod;

  // A terminator advances only when the result slot is free
  assign s1_adv = s1_valid && (!s1_is_end || !out_valid || result.ready);
  assign chars.ready = !s1_valid || s1_adv;

  assign result.valid   = out_valid;
  assign result.verdict = verdict;

  // Hold the accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.valid && chars.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (chars.valid && chars.ready) begin
      s1_ch     <= chars.ch;
      s1_is_end <= chars.is_end;
    end
  end

  sgrv_num_check u_num_check (
    .phase (phase),
    .num   (acc),
    .res   (chk)
  );

  assign is_digit = (s1_ch >= CHAR_ZERO) && (s1_ch <= CHAR_NINE);
  assign prod = PROD_W'({acc, 3'b000}) + PROD_W'({acc, 1'b0})
              + PROD_W'(s1_ch[3:0]);

  // Parse one character or close the string
  always_comb begin
    phase_next    = phase;
    acc_next      = acc;
    failed_next   = failed;
    seen_next     = seen;
    all_zero_next = all_zero;
    verdict_next  = VERDICT_DEFAULT;
    if (s1_is_end) begin
      if (seen == '0 || (seen != SEEN_MAX && all_zero)) begin
        verdict_next = VERDICT_DEFAULT;
      end else if (failed || chk.fail) begin
        verdict_next = VERDICT_INVALID;
      end else begin
        verdict_next = VERDICT_VALID;
      end
      phase_next    = PH_NORMAL;
      acc_next      = '0;
      failed_next   = 1'b0;
      seen_next     = '0;
      all_zero_next = 1'b1;
    end else begin
      if (seen != SEEN_MAX) seen_next = seen + SEEN_W'(1);
      if (s1_ch != CHAR_ZERO) all_zero_next = 1'b0;
      if (!failed) begin
        if (is_digit) begin
          acc_next = (prod > PROD_W'(ACC_MAX)) ? ACC_MAX : prod[ACC_W-1:0];
        end else if (s1_ch == CHAR_SEMI) begin
          phase_next  = chk.phase;
          failed_next = chk.fail;
          acc_next    = '0;
        end else begin
          failed_next = 1'b1;
        end
      end
    end
  end

  // Advance parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_NORMAL;
      acc      <= '0;
      failed   <= 1'b0;
      seen     <= '0;
      all_zero <= 1'b1;
    end else if (s1_adv) begin
      phase    <= phase_next;
      acc      <= acc_next;
      failed   <= failed_next;
      seen     <= seen_next;
      all_zero <= all_zero_next;
    end
  end

  // Load the verdict, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_is_end) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (s1_adv && s1_is_end) begin
      verdict <= verdict_next;
    end
  end

  // A new verdict comes only from a terminator in the input register
  a_verdict_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_is_end))
    else $error("verdict appeared without a terminator");

  // A terminator leaves the parser at the start of a string
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_is_end) |=>
      (phase == PH_NORMAL && acc == '0 && !failed && seen == '0 && all_zero))
    else $error("parse state not cleared after terminator");

  // Phase stays within the defined codes
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= PH_XMODE)
    else $error("phase out of range");

  // A held verdict is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !result.ready) |-> !(s1_adv && s1_is_end))
    else $error("terminator advanced into a full result register");

  // Verdict code is always one of the three meanings
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (verdict == VERDICT_DEFAULT || verdict == VERDICT_VALID
                   || verdict == VERDICT_INVALID))
    else $error("undefined verdict code");

endmodule

FILE: hw/rtl/sgrv_num_check.sv
// Check of one finished number against the current parse phase.
// Depends on sgrv_pkg.
module sgrv_num_check
  import sgrv_pkg::*;
(
  input  logic [PHASE_W-1:0] phase,
  input  logic [ACC_W-1:0]   num,
  output num_check_t         res
);

  // Decide next phase or failure for the number just ended
  always_comb begin
    res.fail  = 1'b0;
    res.phase = phase;
    unique case (phase)
      PH_NORMAL: begin
        if (num == CODE_FG_EXT || num == CODE_BG_EXT) begin
          res.phase = PH_XMODE;
        end else if (!code_supported(num)) begin
          res.fail = 1'b1;
        end
      end
      PH_XMODE: begin
        if (num == MODE_RGB) begin
          res.phase = PH_BYTES3;
        end else if (num == MODE_INDEXED) begin
          res.phase = PH_BYTES1;
        end else begin
          res.fail = 1'b1;
        end
      end
      PH_BYTES1, PH_BYTES2, PH_BYTES3: begin
        if (num <= BYTE_MAX) begin
          res.phase = phase - PHASE_W'(1);
        end else begin
          res.fail = 1'b1;
        end
      end
      default: begin
        res.fail = 1'b1;
      end
    endcase
  end

endmodule
